### rtl/core/adsd_pkg.sv
// Shared widths, codes and types of the argmax sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package adsd_pkg;

    // Field widths
    localparam int SCORE_W = 16;
    localparam int INDEX_W = 8;
    localparam int SUM_W   = 27;
    localparam int COUNT_W = 11;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CLASSES = 256;
    localparam int DEF_MAX_STEPS   = 1024;

    // Threshold after reset, 0.3 in Q0.16
    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd19661;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_AVERAGE = 1'b1;

    // One finished step, as handed from front to back
    typedef struct packed {
        logic               keep;
        logic               seq_end;
        logic [INDEX_W-1:0] index;
        logic [SCORE_W-1:0] score;
    } cmd_t;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_AVG
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/adsd_ifs.sv
// Valid/ready channel interfaces for score words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface adsd_score_if;
    import adsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic               step_end;
    logic               sequence_end;

    modport source (output valid, output score, output step_end, output sequence_end,
                    input ready);
    modport sink   (input valid, input score, input step_end, input sequence_end,
                    output ready);
endinterface

interface adsd_result_if;
    import adsd_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [INDEX_W-1:0] token_index;
    logic [SCORE_W-1:0] token_score;
    logic [SCORE_W-1:0] average_score;
    logic               empty_sequence;
    logic               last;

    modport source (output valid, output kind, output token_index, output token_score,
                    output average_score, output empty_sequence, output last,
                    input ready);
    modport sink   (input valid, input kind, input token_index, input token_score,
                    input average_score, input empty_sequence, input last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/adsd_front.sv
// Front end: per-step argmax tracking and threshold classification.
`timescale 1ns / 1ps
`default_nettype none

module adsd_front #(
    parameter int MAX_CLASSES = adsd_pkg::DEF_MAX_CLASSES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [adsd_pkg::SCORE_W-1:0]  keep_threshold,
    adsd_score_if.sink                         scores,
    input  wire adsd_pkg::queue_status_t       qstat,
    output logic                               push,
    output adsd_pkg::cmd_t                     cmd
);
    import adsd_pkg::*;

    localparam int INDEX_MAX     = (1 << INDEX_W) - 1;
    localparam int INDEX_CAP_INT = (MAX_CLASSES - 1 < INDEX_MAX) ? MAX_CLASSES - 1 : INDEX_MAX;
    localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_W'(INDEX_CAP_INT);

    logic [SCORE_W-1:0] best_score_reg,    best_score_next;
    logic [INDEX_W-1:0] best_index_reg,    best_index_next;
    logic [INDEX_W-1:0] class_counter_reg, class_counter_next;

    logic               accept;
    logic               take;
    logic [SCORE_W-1:0] cand_score;
    logic [INDEX_W-1:0] cand_index;

    // Stall whenever the queue is full, as it then cannot take a finished step
    assign scores.ready = !qstat.full;
    assign accept       = scores.valid && scores.ready;

    // First class of a step always wins; later ones need a strictly higher score
    always_comb
    begin
        take       = (class_counter_reg == '0) || (scores.score > best_score_reg);
        cand_score = take ? scores.score : best_score_reg;
        cand_index = take ? class_counter_reg : best_index_reg;
    end

    // Hand the finished step to the back end
    always_comb
    begin
        push         = accept && scores.step_end;
        cmd.keep     = (cand_score >= keep_threshold);
        cmd.seq_end  = scores.sequence_end;
        cmd.index    = cand_index;
        cmd.score    = cand_score;
    end

    // Advance the step state; clear it at step end
    always_comb
    begin
        best_score_next    = best_score_reg;
        best_index_next    = best_index_reg;
        class_counter_next = class_counter_reg;
        if (accept)
        begin
            if (scores.step_end)
            begin
                best_score_next    = '0;
                best_index_next    = '0;
                class_counter_next = '0;
            end
            else
            begin
                best_score_next = cand_score;
                best_index_next = cand_index;
                if (class_counter_reg < INDEX_CAP)
                begin
                    class_counter_next = class_counter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg    <= '0;
            best_index_reg    <= '0;
            class_counter_reg <= '0;
        end
        else
        begin
            best_score_reg    <= best_score_next;
            best_index_reg    <= best_index_next;
            class_counter_reg <= class_counter_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/adsd_queue.sv
// Small command queue decoupling the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module adsd_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire adsd_pkg::cmd_t           push_cmd,
    input  wire logic                     pop,
    output adsd_pkg::cmd_t                head_cmd,
    output adsd_pkg::queue_status_t       qstat
);
    import adsd_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH = QCNT_W'(QUEUE_DEPTH);

    cmd_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign qstat.full  = (fill_reg == DEPTH);
    assign qstat.empty = (fill_reg == '0);
    assign head_cmd    = entries[rd_ptr_reg];

    // Write the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // A push into a full queue or a pop from an empty one loses a step
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!qstat.full || pop))
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("command queue underflow");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH)
        else $error("command queue fill count out of range");

endmodule

`default_nettype wire

### rtl/core/adsd_back.sv
// Back end: running sum, serial average divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module adsd_back #(
    parameter int MAX_STEPS = adsd_pkg::DEF_MAX_STEPS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire adsd_pkg::cmd_t           cmd,
    input  wire adsd_pkg::queue_status_t  qstat,
    output logic                          pop,
    adsd_result_if.source                 results
);
    import adsd_pkg::*;

    localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP_INT = (MAX_STEPS < COUNT_MAX) ? MAX_STEPS : COUNT_MAX;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    back_state_t        state_reg, state_next;

    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   dvd_reg;
    logic [COUNT_W-1:0] divisor_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [SCORE_W-1:0] quo_reg;
    logic [STEP_W-1:0]  step_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [SCORE_W-1:0] out_token_reg;
    logic [SCORE_W-1:0] out_avg_reg;
    logic               out_empty_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               load_token;
    logic               load_avg;
    logic               div_start;
    logic               add_ok;
    logic [SUM_W-1:0]   sum_upd;
    logic [COUNT_W-1:0] count_upd;
    logic [COUNT_W:0]   trial;
    logic               trial_ge;

    assign out_free = !out_valid_reg || results.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty && out_free && cmd.seq_end)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = BK_AVG;
                end
            end
            BK_AVG:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop        = 1'b0;
        load_avg   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !qstat.empty && out_free;
            end
            BK_AVG:
            begin
                load_avg = out_free;
            end
            default:
            begin
                pop      = 1'b0;
                load_avg = 1'b0;
            end
        endcase
        load_token = pop && cmd.keep;
        div_start  = pop && cmd.seq_end;
    end

    // Accumulate a kept step unless the count has saturated
    always_comb
    begin
        add_ok    = cmd.keep && (count_reg < COUNT_CAP);
        sum_upd   = add_ok ? sum_reg + SUM_W'(cmd.score) : sum_reg;
        count_upd = add_ok ? count_reg + 1'b1 : count_reg;
    end

    // One restoring-division step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                if (cmd.seq_end)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_upd;
                    count_reg <= count_upd;
                end
            end
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg     <= sum_upd;
            divisor_reg <= count_upd;
            rem_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
        end
        else if (state_reg == BK_DIV)
        begin
            dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
            rem_reg  <= trial_ge ? COUNT_W'(trial - {1'b0, divisor_reg})
                                 : trial[COUNT_W-1:0];
            quo_reg  <= {quo_reg[SCORE_W-2:0], trial_ge};
            step_reg <= step_reg + 1'b1;
        end
    end

    // Output register: hold until taken, load the next word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_token || load_avg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_token)
        begin
            out_kind_reg  <= KIND_TOKEN;
            out_index_reg <= cmd.index;
            out_token_reg <= cmd.score;
            out_avg_reg   <= '0;
            out_empty_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (load_avg)
        begin
            out_kind_reg  <= KIND_AVERAGE;
            out_index_reg <= '0;
            out_token_reg <= '0;
            out_avg_reg   <= (divisor_reg == '0) ? '0 : quo_reg;
            out_empty_reg <= (divisor_reg == '0);
            out_last_reg  <= 1'b1;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.kind           = out_kind_reg;
    assign results.token_index    = out_index_reg;
    assign results.token_score    = out_token_reg;
    assign results.average_score  = out_avg_reg;
    assign results.empty_sequence = out_empty_reg;
    assign results.last           = out_last_reg;

    // The divider starts only from a popped sequence-end command
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && $past(state_reg) != BK_DIV) |-> $past(div_start))
        else $error("divider entered without a sequence end");
    // The average is loaded only after the full number of division steps
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_AVG && $past(state_reg) == BK_DIV) |-> $past(step_reg) == STEP_LAST)
        else $error("divider left early");
    // Only the average word closes a sequence
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.last == (results.kind == KIND_AVERAGE)))
        else $error("last flag does not match word kind");
    // An empty sequence reports a zero average
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.empty_sequence) |-> (results.average_score == '0))
        else $error("empty sequence with nonzero average");

endmodule

`default_nettype wire

### rtl/core/argmax_sequence_decode_core.sv
// Top level of the greedy argmax sequence decoder with confidence threshold.
//
//   channel    dir   handshake        payload
//   scores     in    valid/ready      score[15:0], step_end, sequence_end
//   results    out   valid/ready      kind, token_index, token_score,
//                                     average_score, empty_sequence, last
//   config     in    cfg_write_en     cfg_write_data[15:0] -> keep_threshold
//
// The front end takes one score word per cycle while the command queue has room.
// A sequence end sends the back end through the serial divider (one quotient
// bit per cycle over the 27-bit sum), after which it loads the average word.
// The 4-entry command queue holds up to four step ends while the divider runs, so
// scores stall only when the queue fills up while the divider runs or while results
// are not taken.
// Reset is asynchronous and active low; keep_threshold resets to 0.3 (19661).
// The result register holds a word until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module argmax_sequence_decode_core #(
    parameter int MAX_CLASSES = adsd_pkg::DEF_MAX_CLASSES,
    parameter int MAX_STEPS   = adsd_pkg::DEF_MAX_STEPS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    adsd_score_if.sink                        scores,
    adsd_result_if.source                     results,
    input  wire logic                         cfg_write_en,
    input  wire logic [adsd_pkg::SCORE_W-1:0] cfg_write_data
);
    import adsd_pkg::*;

    logic [SCORE_W-1:0] keep_threshold_reg;
    logic               push;
    logic               pop;
    cmd_t               push_cmd;
    cmd_t               head_cmd;
    queue_status_t      qstat;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write_en)
        begin
            keep_threshold_reg <= cfg_write_data;
        end
    end

    adsd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .keep_threshold (keep_threshold_reg),
        .scores         (scores),
        .qstat          (qstat),
        .push           (push),
        .cmd            (push_cmd)
    );

    adsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    adsd_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (head_cmd),
        .qstat   (qstat),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire
